### src/kphms_pkg.sv
// Shared types and constants of the keypad-set HH:MM:SS countdown timer.
package kphms_pkg;

  typedef enum logic [1:0] {
    MODE_SETUP = 2'd0,
    MODE_COUNT = 2'd1,
    MODE_ALARM = 2'd2
  } mode_e;

  localparam logic ACT_KEY  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam logic [7:0] KEY_ZERO   = 8'h30;
  localparam logic [7:0] KEY_NINE   = 8'h39;
  localparam logic [7:0] KEY_EQUALS = 8'h3D;

  localparam logic [2:0] POS_FULL      = 3'd6;
  localparam logic [6:0] HOURS_MAX_RST = 7'd32;
  localparam logic [6:0] MIN_SEC_LIMIT = 7'd59;

  typedef logic [5:0][3:0] slots_t;

  typedef struct packed {
    logic       action;
    logic [7:0] key_code;
  } req_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] entry_position;
    logic [6:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       buzzer_on;
    logic       pair_rejected;
    logic [3:0] last_digit;
  } rsp_t;

  typedef struct packed {
    logic       digit_ok;
    logic       load_ok;
    logic [2:0] pos;
    slots_t     slots;
    logic       rejected;
    logic [3:0] digit;
    logic [6:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       zero;
  } entry_t;

  typedef struct packed {
    logic [6:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       zero;
  } count_t;

endpackage

### src/kphms_entry.sv
// Keypad entry logic: digit slot fill, pair limit check and time load.
module kphms_entry import kphms_pkg::*; (
  input  logic [7:0] key_i,
  input  logic [2:0] pos_i,
  input  slots_t     slots_i,
  input  logic [6:0] hours_max_i,
  output entry_t     ent_o
);

  logic       is_digit;
  logic [3:0] digit;
  logic [2:0] lo_idx;
  logic [3:0] hi;
  logic [6:0] pair_val;
  logic [6:0] limit;
  logic [6:0] min_full;
  logic [6:0] sec_full;

  always_comb begin
    is_digit = (key_i >= KEY_ZERO) && (key_i <= KEY_NINE);
    digit    = 4'(key_i - KEY_ZERO);
    // An odd fill count means this digit completes a pair.
    lo_idx   = 3'(pos_i - 3'd1);
    hi       = pos_i[0] ? slots_i[lo_idx] : 4'd0;
    pair_val = 7'(hi) * 7'd10 + 7'(digit);
    limit    = (pos_i == 3'd1) ? hours_max_i : MIN_SEC_LIMIT;

    ent_o.digit_ok = is_digit && (pos_i < POS_FULL);
    ent_o.digit    = ent_o.digit_ok ? digit : 4'd0;
    ent_o.rejected = ent_o.digit_ok && pos_i[0] && (pair_val > limit);
    ent_o.pos      = ent_o.rejected ? lo_idx : 3'(pos_i + 3'd1);

    for (int i = 0; i < 6; i++) begin
      ent_o.slots[i] = slots_i[i];
      if (3'(i) == pos_i) begin
        ent_o.slots[i] = digit;
      end
      if (ent_o.rejected && ((3'(i) == pos_i) || (3'(i) == lo_idx))) begin
        ent_o.slots[i] = 4'd0;
      end
    end

    ent_o.load_ok = (key_i == KEY_EQUALS) && (pos_i == POS_FULL);
    ent_o.hours   = 7'(slots_i[0]) * 7'd10 + 7'(slots_i[1]);
    min_full      = 7'(slots_i[2]) * 7'd10 + 7'(slots_i[3]);
    sec_full      = 7'(slots_i[4]) * 7'd10 + 7'(slots_i[5]);
    ent_o.minutes = min_full[5:0];
    ent_o.seconds = sec_full[5:0];
    ent_o.zero    = (ent_o.hours == 7'd0) && (ent_o.minutes == 6'd0)
                    && (ent_o.seconds == 6'd0);
  end

endmodule

### src/kphms_count.sv
// Countdown step: one-second decrement with borrow across seconds, minutes, hours.
module kphms_count import kphms_pkg::*; (
  input  logic       skip_i,
  input  logic [6:0] hours_i,
  input  logic [5:0] minutes_i,
  input  logic [5:0] seconds_i,
  output count_t     cnt_o
);

  always_comb begin
    cnt_o.hours   = hours_i;
    cnt_o.minutes = minutes_i;
    cnt_o.seconds = seconds_i;
    if (!skip_i) begin
      if (seconds_i != 6'd0) begin
        cnt_o.seconds = seconds_i - 6'd1;
      end else begin
        cnt_o.seconds = MIN_SEC_LIMIT[5:0];
        if (minutes_i != 6'd0) begin
          cnt_o.minutes = minutes_i - 6'd1;
        end else begin
          cnt_o.minutes = MIN_SEC_LIMIT[5:0];
          if (hours_i != 7'd0) begin
            cnt_o.hours = hours_i - 7'd1;
          end
        end
      end
    end
    cnt_o.zero = (cnt_o.hours == 7'd0) && (cnt_o.minutes == 6'd0)
                 && (cnt_o.seconds == 6'd0);
  end

endmodule

### src/keypad_set_hms_countdown_top.sv
// Top level of the keypad-set HH:MM:SS countdown timer with alarm buzzer.
// A request is taken into the input register, and once it moves on its result is
// written into the result register, which offers it on the output.
// Throughput: one request per cycle, set by the combinational update between the two
// registers; a stalled result blocks new requests only once the input register is full.
// Reset (rst_ni low, asynchronous) clears the timer state to setup with hours_max at 32.
module keypad_set_hms_countdown_top import kphms_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  req_t       in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rsp_t       out_data_o,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_data_i
);

  // Input register. It holds one request until the result register can take
  // its result; in_stall_o follows out_stall_i only while both are full.
  logic s1_valid_q;
  req_t s1_req_q;

  // Result register.
  logic out_valid_q;
  rsp_t out_data_q;

  // Timer state.
  logic [6:0] hours_max_q;
  mode_e      mode_q, mode_d;
  logic [2:0] pos_q, pos_d;
  slots_t     slots_q, slots_d;
  logic [6:0] hours_q, hours_d;
  logic [5:0] minutes_q, minutes_d;
  logic [5:0] seconds_q, seconds_d;
  logic       skip_q, skip_d;
  logic       buzzer_q, buzzer_d;

  logic       rejected;
  logic [3:0] digit;
  logic       advance;
  logic       fire;
  entry_t     ent;
  count_t     cnt;

  // The held request moves on whenever the result register is empty or its
  // result is being taken in this cycle.
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;

  kphms_entry u_entry (
    .key_i       (s1_req_q.key_code),
    .pos_i       (pos_q),
    .slots_i     (slots_q),
    .hours_max_i (hours_max_q),
    .ent_o       (ent)
  );

  kphms_count u_count (
    .skip_i    (skip_q),
    .hours_i   (hours_q),
    .minutes_i (minutes_q),
    .seconds_i (seconds_q),
    .cnt_o     (cnt)
  );

  // Next state. Keys act only in setup and ticks only while counting or in
  // alarm; every other combination leaves the state as it is but still
  // produces a result.
  always_comb begin
    mode_d    = mode_q;
    pos_d     = pos_q;
    slots_d   = slots_q;
    hours_d   = hours_q;
    minutes_d = minutes_q;
    seconds_d = seconds_q;
    skip_d    = skip_q;
    buzzer_d  = buzzer_q;
    rejected  = 1'b0;
    digit     = 4'd0;
    if (fire) begin
      if (s1_req_q.action == ACT_KEY) begin
        if (mode_q == MODE_SETUP) begin
          if (ent.digit_ok) begin
            pos_d    = ent.pos;
            slots_d  = ent.slots;
            rejected = ent.rejected;
            digit    = ent.digit;
          end else if (ent.load_ok) begin
            hours_d   = ent.hours;
            minutes_d = ent.minutes;
            seconds_d = ent.seconds;
            if (ent.zero) begin
              mode_d   = MODE_ALARM;
              buzzer_d = 1'b0;
            end else begin
              mode_d = MODE_COUNT;
              skip_d = 1'b1;
            end
          end
        end
      end else begin
        unique case (mode_q)
          MODE_COUNT: begin
            skip_d    = 1'b0;
            hours_d   = cnt.hours;
            minutes_d = cnt.minutes;
            seconds_d = cnt.seconds;
            if (cnt.zero) begin
              mode_d   = MODE_ALARM;
              buzzer_d = 1'b0;
            end
          end
          MODE_ALARM: buzzer_d = !buzzer_q;
          MODE_SETUP: ;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hours_max_q <= HOURS_MAX_RST;
      mode_q      <= MODE_SETUP;
      pos_q       <= 3'd0;
      slots_q     <= '0;
      hours_q     <= 7'd0;
      minutes_q   <= 6'd0;
      seconds_q   <= 6'd0;
      skip_q      <= 1'b0;
      buzzer_q    <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
      if (cfg_we_i) begin
        hours_max_q <= cfg_data_i;
      end
      mode_q    <= mode_d;
      pos_q     <= pos_d;
      slots_q   <= slots_d;
      hours_q   <= hours_d;
      minutes_q <= minutes_d;
      seconds_q <= seconds_d;
      skip_q    <= skip_d;
      buzzer_q  <= buzzer_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_req_q <= in_data_i;
    end
    if (fire) begin
      out_data_q.mode           <= mode_d;
      out_data_q.entry_position <= pos_d;
      out_data_q.hours          <= hours_d;
      out_data_q.minutes        <= minutes_d;
      out_data_q.seconds        <= seconds_d;
      out_data_q.buzzer_on      <= buzzer_d;
      out_data_q.pair_rejected  <= rejected;
      out_data_q.last_digit     <= digit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Once the timer has left setup it never returns there.
  a_no_return_to_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_SETUP) |=> (mode_q != MODE_SETUP))
    else $error("timer returned to setup mode");

  // Entering alarm always starts with the buzzer off.
  a_alarm_starts_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_ALARM && mode_d == MODE_ALARM) |=> !buzzer_q)
    else $error("alarm entered with buzzer on");

  // A rejected pair leaves the fill count at the start of a pair, in setup.
  a_reject_even_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.pair_rejected) |->
      (!out_data_o.entry_position[0] && out_data_o.mode == MODE_SETUP))
    else $error("pair rejection left an odd entry position");

  // A request that is held back always sits in the input register.
  a_stall_needs_held_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with nothing held");

endmodule
